@@ hdl/nqpt_pkg.sv @@
// ============================================================================
// nqpt_pkg : shared types and constants for the NVMe queue pair tracker
// Item codes, result codes, controller/datapath command and status structs,
// and the helpers for the queue depth register.
// ============================================================================
package nqpt_pkg;

  localparam int ID_W        = 6;
  localparam int DEPTH_W     = 7;
  localparam int STS_W       = 15;
  localparam int CODE_W      = 16;
  localparam int MAX_IDS_DEF = 64;
  localparam int MASK_W      = 64;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET    = 7'd64;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN      = 7'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX      = 7'd64;
  localparam logic [CODE_W-1:0]  GIVE_UP_CODE   = 16'hFFFF;
  localparam logic [APB_AW-1:0]  ADDR_QUEUE_DEPTH = 3'd0;

  typedef enum logic [1:0] {
    KIND_SUBMIT   = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_COLLECT  = 2'd2,
    KIND_GIVE_UP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_OK       = 3'd0,
    OUT_FULL     = 3'd1,
    OUT_STALE    = 3'd2,
    OUT_NOT_DONE = 3'd3,
    OUT_GAVE_UP  = 3'd4,
    OUT_BAD_ID   = 3'd5
  } outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the item, read the status memory
    logic exec;     // commit state update and load result register
    logic cfg_wr;   // queue depth write, clears the queue state
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_stall; // result register full and not being taken
  } dp_sts_t;

  function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] v);
    logic [DEPTH_W-1:0] r;
    r = v;
    if (v < DEPTH_MIN) r = DEPTH_MIN;
    if (v > DEPTH_MAX) r = DEPTH_MAX;
    return r;
  endfunction

  // bit i set where i is below the limit
  function automatic logic [MASK_W-1:0] lim_mask(input logic [DEPTH_W-1:0] lim);
    logic [MASK_W-1:0] m;
    for (int i = 0; i < MASK_W; i++) begin
      m[i] = (DEPTH_W'(i) < lim);
    end
    return m;
  endfunction

endpackage

@@ hdl/nqpt_in_if.sv @@
// ============================================================================
// nqpt_in_if : item channel of the queue pair tracker
// valid/ready handshake carrying one queue item per beat.
// ============================================================================
interface nqpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        entry_phase;
  logic [14:0] entry_status;
  logic [5:0]  command_id;

  modport source (output valid, kind, entry_phase, entry_status, command_id, input ready);
  modport sink   (input valid, kind, entry_phase, entry_status, command_id, output ready);
endinterface

@@ hdl/nqpt_out_if.sv @@
// ============================================================================
// nqpt_out_if : result channel of the queue pair tracker
// valid/ready handshake carrying one result per beat.
// ============================================================================
interface nqpt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  outcome;
  logic [5:0]  granted_id;
  logic [5:0]  slot_index;
  logic [5:0]  sq_doorbell;
  logic [5:0]  cq_doorbell;
  logic [15:0] status_code;

  modport source (output valid, outcome, granted_id, slot_index, sq_doorbell, cq_doorbell,
                  status_code, input ready);
  modport sink   (input valid, outcome, granted_id, slot_index, sq_doorbell, cq_doorbell,
                  status_code, output ready);
endinterface

@@ hdl/nvme_queue_pair_tracker_unit.sv @@
// ============================================================================
// nvme_queue_pair_tracker_unit : host-side NVMe SQ/CQ pair bookkeeping
// Command id allocation, doorbell tracking and completion phase checking.
// ============================================================================
// Usage
//   in_bus  : one beat per queue item (submit, completion entry, collect,
//             give up). Accepted when valid and ready are both high.
//   out_bus : one result beat per item, in order. sq/cq doorbells always
//             show the pointers after the item.
//   APB     : queue_depth at byte address 0; a write clears all queue state
//             (ids, done marks, pointers, phase). Write only while idle.
// Sequencing
//   An item is first captured, with a read of the per-id status memory
//   (registered read), then committed: the bitmaps and pointers update
//   and the result register loads. The commit waits while a pending
//   result is not being taken. in_ready is back high from the commit, so
//   the next item can be accepted at the edge where the result is first
//   taken. Only one item is in flight at a time. A pending result never
//   blocks a capture.
// Reset / stall
//   rst_n (sync) sets depth 64, frees all ids, pointers 0, phase 1. The
//   status memory is not cleared; entries are only read once written.
//   If the result is not taken, the second item waits in its commit cycle
//   with in_ready low, so the input stalls until the result beat goes.
// ============================================================================
module nvme_queue_pair_tracker_unit import nqpt_pkg::*; #(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  nqpt_in_if.sink           in_bus,
  nqpt_out_if.source        out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  ctl_cmd_t           cmd;
  dp_sts_t            sts;
  logic [DEPTH_W-1:0] depth;

  // sequencer: decides when an item is latched and when it commits
  nqpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state, status store and result register
  nqpt_datapath #(
    .MAX_IDS (MAX_IDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_bus.kind),
    .in_entry_phase  (in_bus.entry_phase),
    .in_entry_status (in_bus.entry_status),
    .in_command_id   (in_bus.command_id),
    .pwdata          (pwdata),
    .depth           (depth),
    .out_ready       (out_bus.ready),
    .out_valid       (out_bus.valid),
    .out_outcome     (out_bus.outcome),
    .out_granted_id  (out_bus.granted_id),
    .out_slot_index  (out_bus.slot_index),
    .out_sq_doorbell (out_bus.sq_doorbell),
    .out_cq_doorbell (out_bus.cq_doorbell),
    .out_status_code (out_bus.status_code)
  );

  // zero-wait APB; unmapped addresses read as zero
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_QUEUE_DEPTH) ? APB_DW'(depth) : '0;

  // one item in flight: no capture straight after a capture
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("item accepted while previous one still in flight");

  // a fresh result coincides with the controller going back to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> in_bus.ready)
    else $error("result loaded but controller not idle");

  // only a granted submit carries an id and slot
  a_grant_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.outcome != OUT_OK)) |->
      (out_bus.granted_id == '0) && (out_bus.slot_index == '0))
    else $error("grant fields set on a non-ok result");

  // collect and give up are the only sources of a status code
  a_code_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && ((out_bus.outcome == OUT_FULL) || (out_bus.outcome == OUT_STALE) ||
      (out_bus.outcome == OUT_NOT_DONE) || (out_bus.outcome == OUT_BAD_ID))) |->
      (out_bus.status_code == '0))
    else $error("status code set on a result that carries none");

endmodule

@@ hdl/nqpt_ctrl.sv @@
// ============================================================================
// nqpt_ctrl : sequencing for the queue pair tracker
// Two-state controller: capture an item, then commit it once the result
// register can take the answer.
// ============================================================================
module nqpt_ctrl import nqpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  dp_sts_t           sts,
  output ctl_cmd_t          cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!sts.out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && (state_r == ST_IDLE);
  assign cmd.exec    = (state_r == ST_EXEC) && !sts.out_stall;
  assign cmd.cfg_wr  = psel && penable && pwrite && (paddr == ADDR_QUEUE_DEPTH);

endmodule

@@ hdl/nqpt_datapath.sv @@
// ============================================================================
// nqpt_datapath : queue state, status memory and result register
// Id bitmaps, ring pointers, phase, per-id status store and next-state logic.
// ============================================================================
module nqpt_datapath import nqpt_pkg::*; #(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctl_cmd_t           cmd,
  output dp_sts_t            sts,
  input  logic [1:0]         in_kind,
  input  logic               in_entry_phase,
  input  logic [STS_W-1:0]   in_entry_status,
  input  logic [ID_W-1:0]    in_command_id,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [DEPTH_W-1:0] depth,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [2:0]         out_outcome,
  output logic [ID_W-1:0]    out_granted_id,
  output logic [ID_W-1:0]    out_slot_index,
  output logic [ID_W-1:0]    out_sq_doorbell,
  output logic [ID_W-1:0]    out_cq_doorbell,
  output logic [CODE_W-1:0]  out_status_code
);

  localparam int IDX_W = $clog2(MAX_IDS);
  localparam logic [DEPTH_W-1:0] MAX_LIM = DEPTH_W'(MAX_IDS);

  // queue state
  logic [DEPTH_W-1:0] depth_r;
  logic [MAX_IDS-1:0] in_use_r, in_use_nxt;
  logic [MAX_IDS-1:0] done_r, done_nxt;
  logic [ID_W-1:0]    tail_r, tail_nxt;
  logic [ID_W-1:0]    head_r, head_nxt;
  logic               phase_r, phase_nxt;

  // captured item
  kind_t              kind_r;
  logic               ephase_r;
  logic [STS_W-1:0]   estat_r;
  logic [ID_W-1:0]    cid_r;

  // status memory
  logic [STS_W-1:0]   mem [MAX_IDS];
  logic [STS_W-1:0]   rd_r;
  logic               mem_we;

  // result register
  logic               out_valid_r;
  outcome_t           outcome_r, outcome_nxt;
  logic [ID_W-1:0]    grant_r, grant_nxt;
  logic [ID_W-1:0]    slot_r, slot_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;

  logic [DEPTH_W-1:0] lim, new_depth, new_lim;
  logic [MASK_W-1:0]  mask64, new_mask64;
  logic [MAX_IDS-1:0] mask, free;
  logic [IDX_W-1:0]   cidx, grant_idx;
  logic               in_range;
  logic [ID_W-1:0]    tail_inc, head_inc;

  assign lim        = (depth_r > MAX_LIM) ? MAX_LIM : depth_r;
  assign mask64     = lim_mask(lim);
  assign mask       = mask64[MAX_IDS-1:0];
  assign new_depth  = clamp_depth(pwdata[DEPTH_W-1:0]);
  assign new_lim    = (new_depth > MAX_LIM) ? MAX_LIM : new_depth;
  assign new_mask64 = lim_mask(new_lim);

  assign cidx     = cid_r[IDX_W-1:0];
  assign in_range = ({1'b0, cid_r} < lim);
  assign free     = ~in_use_r & mask;

  // lowest free id
  always_comb begin
    grant_idx = '0;
    for (int i = MAX_IDS - 1; i >= 0; i--) begin
      if (free[i]) grant_idx = IDX_W'(i);
    end
  end

  assign tail_inc = ((DEPTH_W'(tail_r) + 1'b1) == depth_r) ? '0 : tail_r + 1'b1;
  assign head_inc = ((DEPTH_W'(head_r) + 1'b1) == depth_r) ? '0 : head_r + 1'b1;

  always_comb begin
    in_use_nxt  = in_use_r;
    done_nxt    = done_r;
    tail_nxt    = tail_r;
    head_nxt    = head_r;
    phase_nxt   = phase_r;
    mem_we      = 1'b0;
    outcome_nxt = OUT_OK;
    grant_nxt   = '0;
    slot_nxt    = '0;
    code_nxt    = '0;
    unique case (kind_r)
      KIND_SUBMIT: begin
        if (free == '0) begin
          outcome_nxt = OUT_FULL;
        end else begin
          in_use_nxt[grant_idx] = 1'b1;
          done_nxt[grant_idx]   = 1'b0;
          grant_nxt             = ID_W'(grant_idx);
          slot_nxt              = tail_r;
          tail_nxt              = tail_inc;
        end
      end
      KIND_COMPLETE: begin
        if (ephase_r != phase_r) begin
          outcome_nxt = OUT_STALE;
        end else begin
          if (in_range && in_use_r[cidx] && !done_r[cidx]) begin
            mem_we         = 1'b1;
            done_nxt[cidx] = 1'b1;
          end else begin
            outcome_nxt = OUT_BAD_ID;
          end
          head_nxt = head_inc;
          if (head_inc == '0) phase_nxt = ~phase_r;
        end
      end
      KIND_COLLECT: begin
        if (in_range && in_use_r[cidx] && done_r[cidx]) begin
          code_nxt         = {1'b0, rd_r};
          in_use_nxt[cidx] = 1'b0;
        end else begin
          outcome_nxt = OUT_NOT_DONE;
        end
      end
      KIND_GIVE_UP: begin
        if (in_range) in_use_nxt[cidx] = 1'b0;
        outcome_nxt = OUT_GAVE_UP;
        code_nxt    = GIVE_UP_CODE;
      end
      default: outcome_nxt = OUT_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_RESET;
      in_use_r <= '0;
      done_r   <= '0;
      tail_r   <= '0;
      head_r   <= '0;
      phase_r  <= 1'b1;
    end else if (cmd.cfg_wr) begin
      depth_r  <= new_depth;
      in_use_r <= ~new_mask64[MAX_IDS-1:0];
      done_r   <= '0;
      tail_r   <= '0;
      head_r   <= '0;
      phase_r  <= 1'b1;
    end else if (cmd.exec) begin
      in_use_r <= in_use_nxt;
      done_r   <= done_nxt;
      tail_r   <= tail_nxt;
      head_r   <= head_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= kind_t'(in_kind);
      ephase_r <= in_entry_phase;
      estat_r  <= in_entry_status;
      cid_r    <= in_command_id;
      rd_r     <= mem[in_command_id[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) mem[cidx] <= estat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      outcome_r <= outcome_nxt;
      grant_r   <= grant_nxt;
      slot_r    <= slot_nxt;
      code_r    <= code_nxt;
    end
  end

  assign sts.out_stall   = out_valid_r && !out_ready;
  assign depth           = depth_r;
  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_granted_id  = grant_r;
  assign out_slot_index  = slot_r;
  assign out_sq_doorbell = tail_r;
  assign out_cq_doorbell = head_r;
  assign out_status_code = code_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking regression for nvme_queue_pair_tracker_unit
// Directed beats for every kind of queue item and each corner case, then
// random traffic made mostly of legal command lifecycles over many queue
// depths. A scoreboard predicts each result beat and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import nqpt_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int CYCLE_CAP  = 400000;
  localparam int LOG_CAP    = 30;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 86;

  // One queue item as the sender holds it; hold = wait for all results first
  typedef struct packed {
    kind_t       kind;
    logic        phase;
    logic [14:0] status;
    logic [5:0]  cid;
    logic        hold;
  } qitem_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [5:0]  granted;
    logic [5:0]  slot;
    logic [5:0]  sq_db;
    logic [5:0]  cq_db;
    logic [15:0] code;
  } qresult_t;

  // Host-side view of the queue pair
  typedef struct packed {
    logic [6:0]        depth;
    logic [63:0]       in_use;
    logic [63:0]       done;
    logic [63:0][14:0] sts;
    logic [5:0]        tail;
    logic [5:0]        head;
    logic              phase;
  } qpair_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  nqpt_in_if  in_bus ();
  nqpt_out_if out_bus ();

  nvme_queue_pair_tracker_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qitem_t   queued_cmds [$];   // items waiting for the sender
  qresult_t due_results [$];   // predicted result beats, oldest first
  qpair_t   host_view;         // advanced as beats are accepted
  qpair_t   plan_view;         // advanced as items are generated
  qitem_t   cur_item;

  int errors;
  int cycles;
  int results_seen;
  int items_sent;
  int items_queued;
  int depth_writes;
  int outcome_seen [6];

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A depth write clamps to 1..64 and clears ids, done marks, pointers, phase.
  // Ids at and above the depth stay reserved (MAX_IDS is 64 here).
  function automatic void qp_set_depth(inout qpair_t s, input logic [31:0] raw);
    logic [6:0] d;
    d = raw[6:0];
    if (d < 7'd1)  d = 7'd1;
    if (d > 7'd64) d = 7'd64;
    s.depth  = d;
    s.in_use = (d == 7'd64) ? 64'd0 : ~((64'd1 << d) - 64'd1);
    s.done   = '0;
    s.tail   = '0;
    s.head   = '0;
    s.phase  = 1'b1;
  endfunction

  function automatic void qp_advance(inout qpair_t s, input qitem_t it, output qresult_t r);
    logic [63:0] free_ids;
    logic        known;
    int          lim, nid;
    r = '0;
    r.outcome = OUT_OK;
    lim = int'(s.depth);
    known = (int'(it.cid) < lim) && s.in_use[it.cid];
    case (it.kind)
      KIND_SUBMIT: begin
        free_ids = ~s.in_use;
        if (lim < 64) free_ids &= (64'd1 << lim) - 64'd1;
        if (free_ids == '0) begin
          r.outcome = OUT_FULL;
        end else begin
          nid = 0;
          for (int i = 63; i >= 0; i--) if (free_ids[i]) nid = i;
          s.in_use[nid] = 1'b1;
          s.done[nid]   = 1'b0;
          s.sts[nid]    = '0;
          r.granted = 6'(nid);
          r.slot    = s.tail;
          s.tail    = 6'((int'(s.tail) + 1) % lim);
        end
      end
      KIND_COMPLETE: begin
        if (it.phase != s.phase) begin
          r.outcome = OUT_STALE;
        end else begin
          // bad id still consumes the entry
          if (known && !s.done[it.cid]) begin
            s.sts[it.cid]  = it.status;
            s.done[it.cid] = 1'b1;
          end else begin
            r.outcome = OUT_BAD_ID;
          end
          s.head = 6'((int'(s.head) + 1) % lim);
          if (s.head == '0) s.phase = ~s.phase;
        end
      end
      KIND_COLLECT: begin
        if (known && s.done[it.cid]) begin
          r.code = {1'b0, s.sts[it.cid]};
          s.in_use[it.cid] = 1'b0;
        end else begin
          r.outcome = OUT_NOT_DONE;
        end
      end
      default: begin
        if (int'(it.cid) < lim) s.in_use[it.cid] = 1'b0;
        r.outcome = OUT_GAVE_UP;
        r.code    = GIVE_UP_CODE;
      end
    endcase
    r.sq_db = s.tail;
    r.cq_db = s.head;
  endfunction

  // random set bit of a mask, -1 when empty
  function automatic int pick_set_bit(input logic [63:0] mask);
    int start;
    if (mask == '0) return -1;
    start = $urandom_range(0, 63);
    for (int k = 0; k < 64; k++) if (mask[(start + k) % 64]) return (start + k) % 64;
    return -1;
  endfunction

  task automatic queue_item(input kind_t k, input logic ph, input logic [14:0] st,
                            input logic [5:0] id, input logic hold);
    qitem_t   it;
    qresult_t unused_r;
    it.kind   = k;
    it.phase  = ph;
    it.status = st;
    it.cid    = id;
    it.hold   = hold;
    qp_advance(plan_view, it, unused_r);
    queued_cmds.push_back(it);
    items_queued++;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= LOG_CAP) $display("%0t  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("beat %0d %s got %0d want %0d", results_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("nvme_queue_pair_tracker_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offers queued items in bursts with random gaps. An item marked
  // hold is not offered until every result due so far has come back.
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    qresult_t r;
    qitem_t   nxt;
    logic     nv;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      nv = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        qp_advance(host_view, cur_item, r);
        due_results.push_back(r);
        items_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (queued_cmds.size() > 0 &&
                     !(queued_cmds[0].hold && due_results.size() > 0)) begin
          nxt      = queued_cmds.pop_front();
          cur_item = nxt;
          nv       = 1'b1;
          in_bus.kind         <= nxt.kind;
          in_bus.entry_phase  <= nxt.phase;
          in_bus.entry_status <= nxt.status;
          in_bus.command_id   <= nxt.cid;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      in_bus.valid <= nv;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: the stall pattern is redrawn at random among four modes; twice
  // it holds off for a long stretch so the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  int       hold_left;
  int       holds_done;
  int       rx_mode;
  int       rx_tick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left  = 0;
      holds_done = 0;
      rx_mode    = 0;
      rx_tick    = 0;
    end else begin
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if ((holds_done == 0 && results_seen >= 320) ||
                   (holds_done == 1 && results_seen >= 760)) begin
        holds_done++;
        hold_left = 80;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 1) == 0);
          2:       out_bus.ready <= ($urandom_range(0, 9) < 8);
          default: out_bus.ready <= rx_tick[0];
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: each result beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    qresult_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing due", results_seen));
      end else begin
        want = due_results.pop_front();
        check_field("outcome",     int'(out_bus.outcome),     int'(want.outcome));
        check_field("granted_id",  int'(out_bus.granted_id),  int'(want.granted));
        check_field("slot_index",  int'(out_bus.slot_index),  int'(want.slot));
        check_field("sq_doorbell", int'(out_bus.sq_doorbell), int'(want.sq_db));
        check_field("cq_doorbell", int'(out_bus.cq_doorbell), int'(want.cq_db));
        check_field("status_code", int'(out_bus.status_code), int'(want.code));
        outcome_seen[int'(want.outcome)]++;
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // quiet: every queued item accepted and every result beat back
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_cmds.size() != 0 || items_sent != items_queued ||
           due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write of queue_depth: setup, access, written at the access edge
  task automatic write_depth(input logic [31:0] raw);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_QUEUE_DEPTH;
    pwdata  <= raw;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    qp_set_depth(host_view, raw);
    qp_set_depth(plan_view, raw);
    depth_writes++;
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] raw;
    logic [63:0] cand;
    int          sub_w, r, pick;
    kind_t       k;
    logic        ph;
    logic [5:0]  id;

    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_bus.valid        = 1'b0;
    in_bus.kind         = KIND_SUBMIT;
    in_bus.entry_phase  = 1'b0;
    in_bus.entry_status = '0;
    in_bus.command_id   = '0;
    out_bus.ready       = 1'b0;
    errors = 0; cycles = 0; results_seen = 0; items_sent = 0; depth_writes = 0;
    items_queued = 0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;

    host_view = '0;
    qp_set_depth(host_view, 32'd64);
    plan_view = host_view;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed, reset depth 64 ----
    queue_item(KIND_COMPLETE, 1'b0, 15'h1234, 6'd0,  1'b0); // wrong phase: stale
    queue_item(KIND_COLLECT,  1'b0, 15'd0,    6'd5,  1'b0); // never submitted
    queue_item(KIND_GIVE_UP,  1'b1, 15'd0,    6'd63, 1'b0); // unused id
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0);
    queue_item(KIND_SUBMIT,   1'b1, 15'h7FFF, 6'd63, 1'b0);
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0);
    queue_item(KIND_COMPLETE, 1'b1, 15'h7FFF, 6'd1,  1'b0);
    queue_item(KIND_COMPLETE, 1'b1, 15'h0001, 6'd1,  1'b0); // already done
    queue_item(KIND_COMPLETE, 1'b1, 15'h0002, 6'd40, 1'b0); // not in use
    queue_item(KIND_COLLECT,  1'b0, 15'd0,    6'd1,  1'b0);
    queue_item(KIND_COLLECT,  1'b0, 15'd0,    6'd1,  1'b0); // freed already
    queue_item(KIND_GIVE_UP,  1'b0, 15'd0,    6'd2,  1'b0);
    wait_idle();

    // ---- directed, depth 2: full, wrap with phase flip, reserved ids ----
    write_depth(32'd2);
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0);
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0);
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0); // no free id
    queue_item(KIND_COMPLETE, 1'b1, 15'h00AA, 6'd0,  1'b0);
    queue_item(KIND_COMPLETE, 1'b1, 15'h5555, 6'd1,  1'b0); // head wraps
    queue_item(KIND_COMPLETE, 1'b1, 15'h0003, 6'd0,  1'b0); // old phase: stale
    queue_item(KIND_COMPLETE, 1'b0, 15'h0004, 6'd3,  1'b0); // above depth
    queue_item(KIND_COLLECT,  1'b0, 15'd0,    6'd0,  1'b0);
    queue_item(KIND_GIVE_UP,  1'b0, 15'd0,    6'd5,  1'b0); // stays reserved
    wait_idle();

    // ---- directed, depth 0 acts as 1 ----
    write_depth(32'd0);
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0);
    queue_item(KIND_SUBMIT,   1'b0, 15'd0,    6'd0,  1'b0); // full
    wait_idle();

    // ---- random phases over many depths, extremes first ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       raw = 32'h0000_0040;
        1:       raw = 32'd1;
        2:       raw = 32'd2;
        3:       raw = 32'd3;
        4:       raw = 32'h0000_007F;   // clamps to 64
        5:       raw = 32'hFFFF_FF80;   // low bits zero: acts as 1
        6:       raw = 32'hFFFF_FFFF;
        default: begin
          raw      = $urandom;
          raw[6:0] = 7'($urandom_range(1, 64));
        end
      endcase
      write_depth(raw);
      sub_w = $urandom_range(25, 55);
      for (int n = 0; n < PHASE_LEN; n++) begin
        r  = $urandom_range(0, 99);
        ph = plan_view.phase;
        id = 6'($urandom);
        if (r < sub_w) begin
          k = KIND_SUBMIT;
          ph = 1'($urandom);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            k    = KIND_COMPLETE;
            cand = plan_view.in_use & ~plan_view.done;
            if (plan_view.depth < 7'd64) cand &= (64'd1 << plan_view.depth) - 64'd1;
            pick = pick_set_bit(cand);
            if (pick >= 0 && $urandom_range(0, 99) < 88) id = 6'(pick);
            else ph = 1'($urandom);                 // noise entry
          end else if (r < 75) begin
            k    = KIND_COLLECT;
            pick = pick_set_bit(plan_view.in_use & plan_view.done);
            if (pick >= 0 && $urandom_range(0, 99) < 85) id = 6'(pick);
            ph = 1'($urandom);
          end else begin
            k    = KIND_GIVE_UP;
            pick = pick_set_bit(plan_view.in_use);
            if (pick >= 0 && $urandom_range(0, 1) == 0) id = 6'(pick);
            ph = 1'($urandom);
          end
        end
        // sender pause on a few phases: wait for every result to drain
        queue_item(k, ph, 15'($urandom), id, (p % 4 == 1) && (n == PHASE_LEN / 2));
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d items over %0d depth settings with two long receiver hold-offs",
             items_sent, depth_writes + 1);
    $display("outcomes: ok %0d  full %0d  stale %0d  not done %0d  gave up %0d  bad id %0d",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4], outcome_seen[5]);
    if (errors == 0 && due_results.size() == 0) begin
      $display("nvme_queue_pair_tracker_unit regression: pass");
    end else begin
      $display("nvme_queue_pair_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule
